>>> sv/lfpd_pkg.sv
`default_nettype none

package lfpd_pkg;

  // field and register widths
  localparam int SENS_W      = 8;
  localparam int DT_W        = 16;
  localparam int GAIN_W      = 24;
  localparam int LIM_W       = 15;
  localparam int DRV_W       = 16;
  localparam int CTL_W       = 15;

  // error covers every sensor count up to 32 with the first eight sensors wired
  localparam int ERR_W       = 10;
  localparam int INTEG_W     = 40;
  localparam int INTEG_LO_W  = 20;
  localparam int PTERM_W     = GAIN_W + ERR_W;
  localparam int DPROD_W     = GAIN_W + ERR_W + 1;
  localparam int ILO_W       = GAIN_W + INTEG_LO_W + 1;
  localparam int IHI_W       = GAIN_W + INTEG_W - INTEG_LO_W;
  localparam int ISUM_W      = 64;
  localparam int ITERM_W     = LIM_W + 3;
  localparam int SUM_W       = DPROD_W + 2;

  // fixed point constants, Q2.14
  localparam int ONE_Q14     = 16384;
  localparam int HALF_Q14    = 8192;

  // defaults
  localparam int SENSOR_COUNT_DEF = 8;
  localparam int LIM_RESET        = 3277;
  localparam int QUEUE_DEPTH      = 2;

  // configuration port
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P         = 4'd0,
    REG_GAIN_I         = 4'd1,
    REG_GAIN_D         = 4'd2,
    REG_INTEGRAL_LIMIT = 4'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic        [LIM_W-1:0]  integral_limit;
  } cfg_t;

  // one classified step between front and back
  typedef struct packed {
    logic                    zero_dt;
    logic signed [ERR_W-1:0] err;
    logic [DT_W-1:0]         dt;
  } job_t;

  typedef struct packed {
    logic                      start;
    logic signed [DPROD_W-1:0] num;
    logic [DT_W-1:0]           den;
  } div_req_t;

  typedef struct packed {
    logic                      busy;
    logic signed [DPROD_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INTEG,
    S_MUL_LO,
    S_MUL_HI,
    S_ISUM,
    S_ICLAMP,
    S_DIV,
    S_SUM,
    S_FIN
  } back_state_t;

endpackage

`default_nettype wire

>>> sv/lfpd_front.sv
`default_nettype none

module lfpd_front import lfpd_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [SENS_W-1:0] sensor_bits,
  input  wire logic [DT_W-1:0]   elapsed_ms,
  input  wire logic              q_full,
  output logic                   q_push,
  output job_t                   q_job
);

  localparam int USED = (SENSOR_COUNT < SENS_W) ? SENSOR_COUNT : SENS_W;
  localparam logic signed [ERR_W-1:0] HALF_E = ERR_W'(SENSOR_COUNT / 2);

  logic signed [ERR_W-1:0] pos;

  // line position: sum of sensor offsets from the center
  always_comb begin
    pos = '0;
    for (int i = 0; i < USED; i++) begin
      if (sensor_bits[i]) begin
        pos = pos + ERR_W'(i) - HALF_E;
      end
    end
  end

  // classify and hand over to the queue
  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;
  assign q_job.err     = -pos;
  assign q_job.dt      = elapsed_ms;
  assign q_job.zero_dt = (elapsed_ms == '0);

endmodule

`default_nettype wire

>>> sv/lfpd_fifo.sv
`default_nettype none

module lfpd_fifo import lfpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> sv/lfpd_div.sv
`default_nettype none

module lfpd_div import lfpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int NUM_W = DPROD_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DT_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DT_W-1:0]  den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic [DT_W:0]    trial;
  logic [DT_W:0]    diff;
  logic             ge;

  // one restoring step per cycle
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      neg_nxt  = req.num[NUM_W-1];
      quo_nxt  = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DT_W-1:0] : trial[DT_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // signed quotient, truncated toward zero
  assign rsp.busy = busy_r;
  assign rsp.quo  = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

`default_nettype wire

>>> sv/lfpd_back.sv
`default_nettype none

module lfpd_back import lfpd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               job_valid,
  input  wire job_t               job,
  output logic                    job_pop,
  output div_req_t                div_req,
  input  wire div_rsp_t           div_rsp,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [DRV_W-1:0] left_drive,
  output logic signed [DRV_W-1:0] right_drive,
  output logic signed [CTL_W-1:0] control_value
);

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]   SUM_THREE = SUM_W'(3);
  localparam logic signed [SUM_W-1:0]   SUM_HALF  = SUM_W'(HALF_Q14);
  localparam logic signed [DRV_W:0]     DRV_ONE   = (DRV_W+1)'(ONE_Q14);

  back_state_t state_r, state_nxt;

  // state kept across steps
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   prev_r, prev_nxt;

  // per step datapath
  logic signed [ERR_W-1:0]   err_r;
  logic [DT_W-1:0]           dt_r;
  logic signed [PTERM_W-1:0] pterm_r;
  logic signed [ERR_W:0]     delta_r;
  logic signed [ILO_W-1:0]   ilo_r;
  logic signed [IHI_W-1:0]   ihi_r;
  logic signed [DPROD_W-1:0] dprod_r;
  logic signed [ISUM_W-1:0]  isum_r;
  logic signed [ITERM_W-1:0] iterm_r;
  logic signed [SUM_W-1:0]   sum_r;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [DRV_W-1:0] left_r, right_r;
  logic signed [CTL_W-1:0] ctl_r;

  logic signed [GAIN_W-1:0]    gain_p, gain_i, gain_d;
  logic signed [ERR_W+DT_W:0]  errdt;
  logic signed [INTEG_W:0]     integ_sum;
  logic signed [INTEG_W-1:0]   integ_sat;
  logic signed [PTERM_W-1:0]   pterm;
  logic signed [ILO_W-1:0]     ilo;
  logic signed [IHI_W-1:0]     ihi;
  logic signed [DPROD_W-1:0]   dprod;
  logic signed [ISUM_W-1:0]    isum;
  logic signed [ISUM_W-1:0]    lim;
  logic signed [ITERM_W-1:0]   iterm;
  logic signed [SUM_W-1:0]     sum;
  logic signed [SUM_W-1:0]     quarter;
  logic signed [CTL_W-1:0]     ctl_val;
  logic signed [DRV_W:0]       ctl4;
  logic signed [DRV_W:0]       left_w, right_w;
  logic                        out_free;
  logic                        fin_write;

  assign gain_p = cfg.gain_p;
  assign gain_i = cfg.gain_i;
  assign gain_d = cfg.gain_d;

  // integral update with saturation
  assign errdt     = err_r * $signed({1'b0, dt_r});
  assign integ_sum = $signed({integ_r[INTEG_W-1], integ_r}) + (INTEG_W+1)'(errdt);
  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
  end

  // products, one register after each
  assign pterm = gain_p * err_r;
  assign ilo   = gain_i * $signed({1'b0, integ_r[INTEG_LO_W-1:0]});
  assign ihi   = gain_i * $signed(integ_r[INTEG_W-1:INTEG_LO_W]);
  assign dprod = gain_d * delta_r;

  // integral term: recombine halves and clamp
  assign isum = (ISUM_W'(ihi_r) <<< INTEG_LO_W) + ISUM_W'(ilo_r);
  assign lim  = $signed({{(ISUM_W-LIM_W-2){1'b0}}, cfg.integral_limit, 2'b00});
  always_comb begin
    if (isum_r > lim) begin
      iterm = ITERM_W'(lim);
    end else if (isum_r < -lim) begin
      iterm = ITERM_W'(-lim);
    end else begin
      iterm = ITERM_W'(isum_r);
    end
  end

  // term sum
  assign sum = SUM_W'(pterm_r) + SUM_W'(iterm_r) + SUM_W'(div_rsp.quo);

  // to Q2.14 with truncation toward zero, then clamp and mix
  assign quarter = sum_r[SUM_W-1] ? ((sum_r + SUM_THREE) >>> 2) : (sum_r >>> 2);
  always_comb begin
    if (quarter > SUM_HALF) begin
      ctl_val = CTL_W'(HALF_Q14);
    end else if (quarter < -SUM_HALF) begin
      ctl_val = CTL_W'(-HALF_Q14);
    end else begin
      ctl_val = CTL_W'(quarter);
    end
  end
  assign ctl4    = (DRV_W+1)'(ctl_val) <<< 2;
  assign left_w  = DRV_ONE - ctl4;
  assign right_w = DRV_ONE + ctl4;

  assign out_free  = !out_valid_r || out_ready;
  assign fin_write = (state_r == S_FIN) && out_free;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    integ_nxt = integ_r;
    prev_nxt  = prev_r;
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          state_nxt = job.zero_dt ? S_FIN : S_INTEG;
        end
      end
      S_INTEG: begin
        integ_nxt = integ_sat;
        prev_nxt  = err_r;
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_ISUM;
      S_ISUM:   state_nxt = S_ICLAMP;
      S_ICLAMP: state_nxt = S_DIV;
      S_DIV: begin
        if (!div_rsp.busy) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM:    state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // derivative divider starts once its product is registered
  assign div_req.start = (state_r == S_MUL_HI);
  assign div_req.num   = dprod_r;
  assign div_req.den   = dt_r;

  // output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_write) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      integ_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (job_pop) begin
      err_r <= job.err;
      dt_r  <= job.dt;
    end
    if (state_r == S_INTEG) begin
      pterm_r <= pterm;
      delta_r <= (ERR_W+1)'(err_r) - (ERR_W+1)'(prev_r);
    end
    if (state_r == S_MUL_LO) begin
      ilo_r   <= ilo;
      dprod_r <= dprod;
    end
    if (state_r == S_MUL_HI) begin
      ihi_r <= ihi;
    end
    if (state_r == S_ISUM) begin
      isum_r <= isum;
    end
    if (state_r == S_ICLAMP) begin
      iterm_r <= iterm;
    end
    if (job_pop && job.zero_dt) begin
      sum_r <= '0;
    end else if (state_r == S_DIV && !div_rsp.busy) begin
      sum_r <= sum;
    end
    if (fin_write) begin
      ctl_r   <= ctl_val;
      left_r  <= (left_w > DRV_ONE) ? DRV_W'(DRV_ONE) : DRV_W'(left_w);
      right_r <= (right_w > DRV_ONE) ? DRV_W'(DRV_ONE) : DRV_W'(right_w);
    end
  end

  assign out_valid     = out_valid_r;
  assign left_drive    = left_r;
  assign right_drive   = right_r;
  assign control_value = ctl_r;

endmodule

`default_nettype wire

>>> sv/line_follow_pid_drive.sv
// channel  | direction | word
// ---------+-----------+-----------------------------------------------------
// in_      | slave     | sensor bits and elapsed milliseconds per control step
// out_     | master    | left drive, right drive and control value
// cfg_     | slave     | register index and write data
//
// a step with nonzero elapsed time runs the integral, product and clamp states
// and the 35-step derivative divider; one with zero elapsed time skips to output
// a two-word queue takes words while the back end works or a result waits;
// in_tready drops only while the queue holds two words
// reset is synchronous and active low, clearing integral, last error,
// queue and registers; no clearing pass follows
`default_nettype none

module line_follow_pid_drive import lfpd_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sensor_bits [7:0], elapsed_ms [23:8]
  input  wire logic [23:0]           in_tdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // left_drive [15:0], right_drive [31:16], control_value [46:32], zero [47]
  output logic [47:0]                out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  job_t     push_job, head_job;
  logic     q_push, q_full, q_pop, q_not_empty;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [DRV_W-1:0] left_drive, right_drive;
  logic signed [CTL_W-1:0] control_value;

  // register file
  assign cfg_ready = 1'b1;
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_P:         cfg_nxt.gain_p         = cfg_data[GAIN_W-1:0];
        REG_GAIN_I:         cfg_nxt.gain_i         = cfg_data[GAIN_W-1:0];
        REG_GAIN_D:         cfg_nxt.gain_d         = cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = cfg_data[LIM_W-1:0];
        default:            cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.integral_limit <= LIM_W'(LIM_RESET);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify
  lfpd_front #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_front (
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .sensor_bits (in_tdata[SENS_W-1:0]),
    .elapsed_ms  (in_tdata[SENS_W+DT_W-1:SENS_W]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  // queue between front and back
  lfpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  // back: pid sequencer
  lfpd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .job_valid     (q_not_empty),
    .job           (head_job),
    .job_pop       (q_pop),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .left_drive    (left_drive),
    .right_drive   (right_drive),
    .control_value (control_value)
  );

  // derivative divider
  lfpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tdata = {1'b0, control_value, right_drive, left_drive};

endmodule

`default_nettype wire
